@@ hdl/upd_pkg.sv @@
// ----------------------------------------------------------------------------
// upd_pkg: shared types and constants for the URL percent decoder
// Character codes, escape phase codes, the result record and hex digit lookup.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Digit value with bit 4 set marks a byte that is not a hex digit
    localparam logic [4:0] NON_NUM = 5'h10;

    // Escape phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    typedef struct packed {
        logic [7:0]  data;
        logic        has_byte;
        logic        last;
        logic [15:0] count;
    } result_t;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = NON_NUM;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 5'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 5'(c - 8'h61 + 8'd10);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 5'(c - 8'h41 + 8'd10);
        end
        return v;
    endfunction

    function automatic logic [7:0] plain_decode(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

endpackage

@@ hdl/url_percent_decoder_core.sv @@
// ----------------------------------------------------------------------------
// url_percent_decoder_core: form-urlencoded percent decoder
// Decodes one source byte per transfer: '+' to space, '%hh' to one byte,
// with a per-string output limit and a final result carrying the length.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ---------------------------------------
//  input     in_valid / in_ready    in_byte, in_last
//  output    out_valid / out_ready  out_byte, has_byte, out_last, out_count
//  config    cfg_we                 cfg_data (out_limit)
//
//  One input transfer per cycle while in_ready is high; each result is
//  registered in the result register, or in the skid register while one
//  is stalled. The escape state and counter update on the transfer itself.
//  A two-entry output buffer (result register plus skid register) lets a
//  new byte enter while a result is stalled; in_ready drops only when both
//  entries are full. Reset clears the escape state, the count, the buffer
//  valid bits and sets the limit to 65535.
//
module url_percent_decoder_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        has_byte,
    output logic        out_last,
    output logic [15:0] out_count
);
    import upd_pkg::*;

    // Compare width covers both the counter and the 16-bit limit
    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [15:0]           limit_reg;
    logic [1:0]            phase_reg, phase_next;
    logic [4:0]            nibble_reg, nibble_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    result_t out_reg, skid_reg, res;
    logic    out_valid_reg, skid_valid_reg;

    logic in_fire, out_fire, produce;
    logic room, emit;
    logic [7:0] dec_byte;
    logic [4:0] lo_val;
    logic [COUNT_BITS-1:0] count_inc;
    logic [CMP_W-1:0] count_ext;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    assign count_ext = CMP_W'(count_reg);
    // Stop once the count meets the limit or the counter saturates
    assign room = (count_ext < CMP_W'(limit_reg)) && (count_reg != '1);
    assign lo_val = hex_value(in_byte);

    // Decode one byte against the escape state
    always_comb
    begin
        emit        = 1'b0;
        dec_byte    = 8'h00;
        phase_next  = phase_reg;
        nibble_next = nibble_reg;
        if (room)
        begin
            case (phase_reg)
                PH_PCT:
                begin
                    if (in_last)
                    begin
                        // '%' second to last: drop it, decode this byte unless '%'
                        phase_next = PH_IDLE;
                        if (in_byte != CH_PERCENT)
                        begin
                            emit     = 1'b1;
                            dec_byte = plain_decode(in_byte);
                        end
                    end
                    else
                    begin
                        nibble_next = lo_val;
                        phase_next  = PH_DIGIT;
                    end
                end
                PH_DIGIT:
                begin
                    if (nibble_reg != NON_NUM && lo_val != NON_NUM)
                    begin
                        emit     = 1'b1;
                        dec_byte = {nibble_reg[3:0], lo_val[3:0]};
                    end
                    phase_next  = PH_IDLE;
                    nibble_next = 5'd0;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (in_byte == CH_PERCENT)
                    begin
                        if (!in_last)
                        begin
                            phase_next = PH_PCT;
                        end
                    end
                    else
                    begin
                        emit     = 1'b1;
                        dec_byte = plain_decode(in_byte);
                    end
                end
            endcase
        end
    end

    assign count_inc = emit ? (count_reg + COUNT_BITS'(1)) : count_reg;
    assign count_next = in_last ? '0 : count_inc;

    always_comb
    begin
        res.data     = dec_byte;
        res.has_byte = emit;
        res.last     = in_last;
        res.count    = 16'(CMP_W'(count_inc));
    end

    assign produce = in_fire && (emit || in_last);

    // Configuration and escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= 16'hFFFF;
            phase_reg  <= PH_IDLE;
            nibble_reg <= 5'd0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            if (in_fire)
            begin
                // End of string returns the escape state to idle
                phase_reg  <= in_last ? PH_IDLE : phase_next;
                nibble_reg <= in_last ? 5'd0 : nibble_next;
                count_reg  <= count_next;
            end
        end
    end

    // Output buffer control: result register first, skid behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= produce;
            end
        end
        else if (produce)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (produce)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_reg.data;
    assign has_byte  = out_reg.has_byte;
    assign out_last  = out_reg.last;
    assign out_count = out_reg.count;

    // The skid entry only fills behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without a result ahead of it");

    // A string end leaves the decoder idle with a cleared count
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_last) |=> (count_reg == '0 && phase_reg == PH_IDLE
                                  && nibble_reg == 5'd0))
        else $error("state not cleared after the last byte");

    // A result without a byte only ever closes a string
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.has_byte) |-> (out_reg.last && out_reg.data == 8'h00))
        else $error("empty result that does not end a string");

    // A transfer that yields nothing must not disturb the output buffer
    a_quiet_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !produce && out_valid_reg && !out_ready) |=>
            (out_valid_reg && !skid_valid_reg))
        else $error("buffer changed on a transfer without a result");

endmodule

@@ sim/url_percent_decoder_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// url_percent_decoder_core_test: self-checking bench for the percent decoder
// Streams encoded strings through the core, predicts every decoded result in
// the bench and compares each output transfer field by field, under random
// idling on both channels, long output stalls and several output limits.
// ----------------------------------------------------------------------------
module url_percent_decoder_core_test;

    import upd_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 40;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        in_last;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        out_last;
    logic [15:0] out_count;

    // Bench copy of the decoder state and the limit register
    logic [1:0]  dec_phase;
    logic [4:0]  dec_high;
    logic [15:0] dec_count;
    logic [15:0] dec_limit;

    // Decoded results still owed by the core, oldest first
    result_t     decoded_due[$];

    int          mismatch_count = 0;
    int          bytes_sent;
    int          cycle_count = 0;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_reqs;
    int          hold_seen = 0;
    int          hold_left = 0;

    url_percent_decoder_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .has_byte  (has_byte),
        .out_last  (out_last),
        .out_count (out_count)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Watchdog: end the run if the traffic never drains
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("url_percent_decoder_core_test: done, errors");
            $finish;
        end
    end

    // Output side: random ready, or a long hold-off when a test asks for one.
    // A request is a bump of hold_reqs; pick it up on the following edge.
    always @(posedge clk)
    begin
        if (hold_reqs != hold_seen)
        begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_REPORTS)
        begin
            $display("MISMATCH at cycle %0d: %s got 0x%0h, expected 0x%0h",
                     cycle_count, what, got, want);
        end
        mismatch_count++;
    endtask

    // Compare every accepted output transfer with the oldest owed result.
    // Inputs are driven with nonblocking updates, so values read here are
    // the ones present at the edge.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_due.size() == 0)
            begin
                report_mismatch("unexpected result, out_count", int'(out_count), 0);
            end
            else
            begin
                want = decoded_due.pop_front();
                if (has_byte !== want.has_byte)
                    report_mismatch("has_byte", int'(has_byte), int'(want.has_byte));
                if (out_byte !== want.data)
                    report_mismatch("out_byte", int'(out_byte), int'(want.data));
                if (out_last !== want.last)
                    report_mismatch("out_last", int'(out_last), int'(want.last));
                if (out_count !== want.count)
                    report_mismatch("out_count", int'(out_count), int'(want.count));
            end
        end
    end

    // Hex digit value; bit 4 set flags a byte that is not a hex digit
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]})
            return {1'b0, c[3:0]};
        if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
            return {1'b0, c[3:0] + 4'd9};
        return NON_NUM;
    endfunction

    // Advance the bench copy of the decoder by one source byte and queue
    // the result it owes, if any.
    task automatic predict_decode(input logic [7:0] c, input logic is_last);
        logic       emit;
        logic [7:0] value;
        logic [4:0] low;
        result_t    r;
        emit  = 1'b0;
        value = 8'h00;
        // Once the limit or the counter ceiling is reached, ignore the byte
        if (dec_count < dec_limit && dec_count != 16'hFFFF)
        begin
            case (dec_phase)
                PH_PCT:
                begin
                    if (is_last)
                    begin
                        // '%' cut off: drop it, decode this byte unless '%'
                        dec_phase = PH_IDLE;
                        if (c != CH_PERCENT)
                        begin
                            emit  = 1'b1;
                            value = (c == CH_PLUS) ? CH_SPACE : c;
                        end
                    end
                    else
                    begin
                        dec_high  = digit_of(c);
                        dec_phase = PH_DIGIT;
                    end
                end
                PH_DIGIT:
                begin
                    low = digit_of(c);
                    // A bad digit on either side swallows the whole escape
                    if (!dec_high[4] && !low[4])
                    begin
                        emit  = 1'b1;
                        value = {dec_high[3:0], low[3:0]};
                    end
                    dec_phase = PH_IDLE;
                    dec_high  = 5'd0;
                end
                default:
                begin
                    dec_phase = PH_IDLE;
                    if (c == CH_PERCENT)
                    begin
                        if (!is_last)
                            dec_phase = PH_PCT;
                    end
                    else
                    begin
                        emit  = 1'b1;
                        value = (c == CH_PLUS) ? CH_SPACE : c;
                    end
                end
            endcase
            if (emit)
                dec_count = dec_count + 16'd1;
        end
        if (emit || is_last)
        begin
            r.data     = value;
            r.has_byte = emit;
            r.last     = is_last;
            r.count    = dec_count;
            decoded_due.push_back(r);
        end
        if (is_last)
        begin
            dec_phase = PH_IDLE;
            dec_high  = 5'd0;
            dec_count = 16'd0;
        end
    endtask

    // Offer one source byte after a random gap and hold it until the
    // transfer. Leave valid high afterwards so back-to-back bytes flow.
    task automatic send_src_byte(input logic [7:0] c, input logic is_last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= c;
        in_last  <= is_last;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        predict_decode(c, is_last);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_src_byte(s[i], i == s.len() - 1);
    endtask

    // Drop valid and hold until every owed result has come out
    task automatic drain_all();
        in_valid <= 1'b0;
        while (decoded_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the output limit with the core idle, at a string boundary
    task automatic set_limit(input logic [15:0] v);
        drain_all();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        dec_limit  = v;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + {4'd0, n};
        return ($urandom_range(1) ? 8'h41 : 8'h61) + {4'd0, n - 4'd10};
    endfunction

    // Build one random string: mostly plain text, '+' and good escapes,
    // with some broken escapes and raw bytes of any value mixed in.
    task automatic send_random_string();
        logic [7:0] src[$];
        int         tokens;
        int         pick;
        int         i;
        logic [7:0] c;
        tokens = $urandom_range(1, 10);
        for (i = 0; i < tokens; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                c = 8'($urandom_range(8'h21, 8'h7E));
                src.push_back((c == CH_PERCENT) ? 8'h78 : c);
            end
            else if (pick < 55)
            begin
                src.push_back(CH_PLUS);
            end
            else if (pick < 85)
            begin
                src.push_back(CH_PERCENT);
                src.push_back(hex_char(4'($urandom_range(15))));
                src.push_back(hex_char(4'($urandom_range(15))));
            end
            else if (pick < 93)
            begin
                src.push_back(CH_PERCENT);
                src.push_back(8'($urandom_range(255)));
                src.push_back(8'($urandom_range(255)));
            end
            else
            begin
                src.push_back(8'($urandom_range(255)));
            end
        end
        for (i = 0; i < src.size(); i++)
            send_src_byte(src[i], i == src.size() - 1);
    endtask

    // Plain text, '+', escapes at both ends of the byte range, malformed
    // escapes and every way a '%' can be cut off by the end of a string.
    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_text("a+b");
        send_text("+%fF%00");
        send_src_byte(8'h00, 1'b0);
        send_src_byte(8'hFF, 1'b1);
        send_text("%g1");
        send_text("%1G");
        send_text("a%");
        send_text("%+");
        send_text("%%");
        send_text("%4");
        drain_all();
    endtask

    // Small limits: bytes past the limit are ignored, escapes included
    task automatic test_limits();
        set_limit(16'd1);
        send_text("ab%41");
        set_limit(16'd2);
        send_text("%41%42%43");
        set_limit(16'd3);
        send_text("+++++");
        send_text("%7E");
        drain_all();
    endtask

    // Stall the output for a long stretch while bytes keep coming, so the
    // buffer fills and the input stalls; then pause until all is out.
    task automatic test_backpressure();
        int i;
        set_limit(16'hFFFF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_reqs <= hold_reqs + 1;
        for (i = 0; i < 60; i++)
            send_src_byte(8'($urandom_range(8'h30, 8'h39)), i == 59);
        drain_all();
    endtask

    task automatic test_random_phase(input int sidle, input int ridle,
                                     input int n_src, input logic [15:0] lim);
        int stop_at;
        set_limit(lim);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        stop_at = bytes_sent + n_src;
        while (bytes_sent < stop_at)
            send_random_string();
        drain_all();
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = 16'd0;
        in_valid       = 1'b0;
        in_byte        = 8'd0;
        in_last        = 1'b0;
        bytes_sent     = 0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        hold_reqs      = 0;
        dec_phase      = PH_IDLE;
        dec_high       = 5'd0;
        dec_count      = 16'd0;
        dec_limit      = 16'hFFFF;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_limits();
        test_backpressure();
        test_random_phase(7, 52, 310, 16'hFFFF);
        test_random_phase(52, 7, 310, 16'($urandom_range(3, 12)));
        test_random_phase(0, 0, 310, 16'hFFFF);
        test_backpressure();

        in_valid <= 1'b0;
        while (decoded_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("url_percent_decoder_core_test: done, clean");
        end
        else
        begin
            $display("url_percent_decoder_core_test: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/upd_pkg.sv
hdl/url_percent_decoder_core.sv
sim/url_percent_decoder_core_test.sv
